>>> src/mtbc_pkg.sv
// ----------------------------------------------------------------------------
// mtbc_pkg
// Shared widths, constants and register codes for the motor thrust battery
// compensation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mtbc_pkg;

   // field widths
   localparam int DEMAND_W  = 12;
   localparam int TRIM_W    = 9;
   localparam int DSUM_W    = 13;   // demand plus trim, signed
   localparam int MV_W      = 16;
   localparam int DUTY_W    = 10;
   localparam int NUM_MOTORS = 4;

   // internal arithmetic widths
   localparam int DEN_W    = 33;    // 100000 * mv
   localparam int COEF_W   = 30;    // linear minus quadratic term, always positive
   localparam int PROD_W   = 44;    // signed numerator
   localparam int REM_W    = 39;    // positive numerator / running remainder
   localparam int LIMIT_W  = 43;    // 999 * denominator

   // scaled polynomial coefficients
   localparam logic signed [31:0] LIN_COEF  = 32'sd528000000;
   localparam logic signed [31:0] QUAD_COEF = 32'sd224604;
   localparam logic [DEN_W-1:0]   DEN_COEF  = DEN_W'(100000);

   // saturation value: the lower of full scale and the pwm top
   localparam logic [DUTY_W-1:0] DUTY_SAT  = DUTY_W'(999);
   localparam logic [DUTY_W-1:0] DUTY_ZERO = '0;

   // pipeline layout
   localparam int STAGES    = 15;
   localparam int DIV_FIRST = 4;
   localparam int DIV_LAST  = 13;
   localparam int OUT_STAGE = 14;
   localparam int DEN_DEPTH = 13;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRIM_MOTOR1 = 3'd0,
      REG_TRIM_MOTOR2 = 3'd1,
      REG_TRIM_MOTOR3 = 3'd2,
      REG_TRIM_MOTOR4 = 3'd3
   } csr_index_type;

   // denominators along the divider stages
   typedef logic [DEN_DEPTH-1:0][DEN_W-1:0] den_pipe_type;

   // shared per-request side information, aligned with the numerator stage
   typedef struct packed {
      logic               stop;
      logic               mv_zero;
      logic [LIMIT_W-1:0] limit;
   } side_type;

endpackage

`default_nettype wire

>>> src/mtbc_lane.sv
// ----------------------------------------------------------------------------
// mtbc_lane
// One motor lane: trim add, polynomial numerator, special-case sorting and
// a ten-stage restoring divider giving the duty value.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbc_lane (
   input  wire logic                                    clock,
   input  wire logic [mtbc_pkg::STAGES-1:0]             stage_en,
   input  wire logic signed [mtbc_pkg::DEMAND_W-1:0]    demand,
   input  wire logic signed [mtbc_pkg::TRIM_W-1:0]      trim,
   input  wire mtbc_pkg::side_type                      side_s2,
   input  wire mtbc_pkg::den_pipe_type                  den,
   output logic [mtbc_pkg::DUTY_W-1:0]                  duty
);

   logic signed [mtbc_pkg::DSUM_W-1:0] d0_ff, d0_in, d1_ff;
   logic [mtbc_pkg::COEF_W-1:0]        c1_ff, c1_in;
   logic signed [31:0]                 quad_term, coef_full;
   logic signed [mtbc_pkg::PROD_W-1:0] n2_ff, n2_in;

   logic [mtbc_pkg::REM_W-1:0]  r_ff     [mtbc_pkg::DIV_FIRST-1:mtbc_pkg::DIV_LAST];
   logic [mtbc_pkg::DUTY_W-1:0] q_ff     [mtbc_pkg::DIV_FIRST-1:mtbc_pkg::DIV_LAST];
   logic                        force_ff [mtbc_pkg::DIV_FIRST-1:mtbc_pkg::DIV_LAST];
   logic [mtbc_pkg::DUTY_W-1:0] fval_ff  [mtbc_pkg::DIV_FIRST-1:mtbc_pkg::DIV_LAST];

   logic                        force3_in;
   logic [mtbc_pkg::DUTY_W-1:0] fval3_in;
   logic [mtbc_pkg::DUTY_W-1:0] duty_ff, duty_in;

   // stage 0: trimmed demand
   assign d0_in = {demand[mtbc_pkg::DEMAND_W-1], demand}
                + {{(mtbc_pkg::DSUM_W-mtbc_pkg::TRIM_W){trim[mtbc_pkg::TRIM_W-1]}}, trim};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d0_ff <= d0_in;
      end
   end

   // stage 1: linear minus quadratic coefficient
   assign quad_term = mtbc_pkg::QUAD_COEF * 32'(d0_ff);
   assign coef_full = mtbc_pkg::LIN_COEF - quad_term;
   assign c1_in     = coef_full[mtbc_pkg::COEF_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         d1_ff <= d0_ff;
         c1_ff <= c1_in;
      end
   end

   // stage 2: numerator d * coefficient
   assign n2_in = mtbc_pkg::PROD_W'(d1_ff) * $signed({14'd0, c1_ff});

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         n2_ff <= n2_in;
      end
   end

   // stage 3: stop, dead battery, non-positive numerator and saturation
   always_comb begin
      force3_in = 1'b1;
      fval3_in  = mtbc_pkg::DUTY_ZERO;
      priority if (side_s2.stop) begin
         fval3_in = mtbc_pkg::DUTY_ZERO;
      end else if (side_s2.mv_zero) begin
         fval3_in = mtbc_pkg::DUTY_SAT;
      end else if (n2_ff[mtbc_pkg::PROD_W-1] || (n2_ff == '0)) begin
         fval3_in = mtbc_pkg::DUTY_ZERO;
      end else if (n2_ff[mtbc_pkg::LIMIT_W-1:0] >= side_s2.limit) begin
         fval3_in = mtbc_pkg::DUTY_SAT;
      end else begin
         force3_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         r_ff[mtbc_pkg::DIV_FIRST-1]     <= n2_ff[mtbc_pkg::REM_W-1:0];
         q_ff[mtbc_pkg::DIV_FIRST-1]     <= '0;
         force_ff[mtbc_pkg::DIV_FIRST-1] <= force3_in;
         fval_ff[mtbc_pkg::DIV_FIRST-1]  <= fval3_in;
      end
   end

   // stages 4..13: one quotient bit per stage, msb first
   for (genvar j = mtbc_pkg::DIV_FIRST; j <= mtbc_pkg::DIV_LAST; j++) begin : g_div
      localparam int K = mtbc_pkg::DIV_LAST - j;
      logic [mtbc_pkg::LIMIT_W-1:0] shifted, rem_ext, rem_diff;
      logic [mtbc_pkg::REM_W-1:0]   r_in;
      logic [mtbc_pkg::DUTY_W-1:0]  q_in;

      assign shifted  = mtbc_pkg::LIMIT_W'(den[j-1]) << K;
      assign rem_ext  = mtbc_pkg::LIMIT_W'(r_ff[j-1]);
      assign rem_diff = rem_ext - shifted;

      always_comb begin
         if (rem_ext >= shifted) begin
            r_in = rem_diff[mtbc_pkg::REM_W-1:0];
            q_in = q_ff[j-1] | (mtbc_pkg::DUTY_W'(1) << K);
         end else begin
            r_in = r_ff[j-1];
            q_in = q_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            r_ff[j]     <= r_in;
            q_ff[j]     <= q_in;
            force_ff[j] <= force_ff[j-1];
            fval_ff[j]  <= fval_ff[j-1];
         end
      end
   end

   // stage 14: final duty select
   assign duty_in = force_ff[mtbc_pkg::DIV_LAST] ? fval_ff[mtbc_pkg::DIV_LAST]
                                                 : q_ff[mtbc_pkg::DIV_LAST];

   always_ff @(posedge clock) begin
      if (stage_en[mtbc_pkg::OUT_STAGE]) begin
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;

endmodule

`default_nettype wire

>>> src/motor_thrust_battery_compensation.sv
// ----------------------------------------------------------------------------
// motor_thrust_battery_compensation
// Four motor demands plus battery voltage to four compensated PWM duties.
// ----------------------------------------------------------------------------
// Fully pipelined over 15 register stages: one request is taken every cycle
// while the output is not stalled, and its response shows on rsp_valid when
// it reaches the output register. The stages are the trim add and the two
// polynomial multipliers (three stages), one special-case sorting stage, the
// ten-stage restoring divider with one quotient bit per stage, and the output
// register. Each stage holds its own valid bit, so bubbles are squeezed out
// and new requests enter while a response waits on rsp_stall.
// Trim registers are written through csr_ with indexes above 3 ignored.
`default_nettype none

module motor_thrust_battery_compensation (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [mtbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mtbc_pkg::TRIM_W-1:0]          csr_wr_data,
   // request
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [mtbc_pkg::DEMAND_W-1:0]        req_demand_motor1,
   input  wire logic [mtbc_pkg::DEMAND_W-1:0]        req_demand_motor2,
   input  wire logic [mtbc_pkg::DEMAND_W-1:0]        req_demand_motor3,
   input  wire logic [mtbc_pkg::DEMAND_W-1:0]        req_demand_motor4,
   input  wire logic [mtbc_pkg::MV_W-1:0]            req_battery_mv,
   input  wire logic                                 req_stop,
   // response
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [mtbc_pkg::DUTY_W-1:0]               rsp_duty_motor1,
   output logic [mtbc_pkg::DUTY_W-1:0]               rsp_duty_motor2,
   output logic [mtbc_pkg::DUTY_W-1:0]               rsp_duty_motor3,
   output logic [mtbc_pkg::DUTY_W-1:0]               rsp_duty_motor4
);

   logic [mtbc_pkg::TRIM_W-1:0]  trim_ff [mtbc_pkg::NUM_MOTORS];
   logic [mtbc_pkg::STAGES-1:0]  valid_ff, valid_in, ready;
   logic [mtbc_pkg::STAGES:0]    ready_chain;

   logic [2:0]                   stop_ff, mvz_ff;
   mtbc_pkg::den_pipe_type       den_ff;
   logic [mtbc_pkg::DEN_W-1:0]   den_in;
   logic [mtbc_pkg::LIMIT_W-1:0] limit1_ff, limit1_in, limit2_ff;
   mtbc_pkg::side_type           side_s2;

   logic [mtbc_pkg::DEMAND_W-1:0] demand_arr [mtbc_pkg::NUM_MOTORS];
   logic [mtbc_pkg::DUTY_W-1:0]   duty_arr   [mtbc_pkg::NUM_MOTORS];

   // trim registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mtbc_pkg::NUM_MOTORS; i++) begin
            trim_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mtbc_pkg::REG_TRIM_MOTOR1: trim_ff[0] <= csr_wr_data;
            mtbc_pkg::REG_TRIM_MOTOR2: trim_ff[1] <= csr_wr_data;
            mtbc_pkg::REG_TRIM_MOTOR3: trim_ff[2] <= csr_wr_data;
            mtbc_pkg::REG_TRIM_MOTOR4: trim_ff[3] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // per-stage ready: a stage loads when empty or when its content moves on
   assign ready_chain[mtbc_pkg::STAGES] = !rsp_stall;
   for (genvar k = 0; k < mtbc_pkg::STAGES; k++) begin : g_ready
      assign ready_chain[k] = !valid_ff[k] || ready_chain[k+1];
      assign ready[k]       = ready_chain[k];
      if (k == 0) begin : g_first
         assign valid_in[k] = req_valid && ready_chain[0];
      end else begin : g_rest
         assign valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !ready_chain[0];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < mtbc_pkg::STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // shared battery path: denominator and saturation limit
   assign den_in    = mtbc_pkg::DEN_W'(req_battery_mv) * mtbc_pkg::DEN_COEF;
   assign limit1_in = mtbc_pkg::LIMIT_W'(den_ff[0])
                    * mtbc_pkg::LIMIT_W'(mtbc_pkg::DUTY_SAT);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         stop_ff[0] <= req_stop;
         mvz_ff[0]  <= (req_battery_mv == '0);
         den_ff[0]  <= den_in;
      end
      if (ready[1]) begin
         stop_ff[1] <= stop_ff[0];
         mvz_ff[1]  <= mvz_ff[0];
         limit1_ff  <= limit1_in;
      end
      if (ready[2]) begin
         stop_ff[2] <= stop_ff[1];
         mvz_ff[2]  <= mvz_ff[1];
         limit2_ff  <= limit1_ff;
      end
      for (int k = 1; k < mtbc_pkg::DEN_DEPTH; k++) begin
         if (ready[k]) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign side_s2 = '{stop: stop_ff[2], mv_zero: mvz_ff[2], limit: limit2_ff};

   // motor lanes
   assign demand_arr[0] = req_demand_motor1;
   assign demand_arr[1] = req_demand_motor2;
   assign demand_arr[2] = req_demand_motor3;
   assign demand_arr[3] = req_demand_motor4;

   for (genvar m = 0; m < mtbc_pkg::NUM_MOTORS; m++) begin : g_lane
      mtbc_lane u_lane (
         .clock    (clock),
         .stage_en (ready),
         .demand   ($signed(demand_arr[m])),
         .trim     ($signed(trim_ff[m])),
         .side_s2  (side_s2),
         .den      (den_ff),
         .duty     (duty_arr[m])
      );
   end

   assign rsp_valid       = valid_ff[mtbc_pkg::OUT_STAGE];
   assign rsp_duty_motor1 = duty_arr[0];
   assign rsp_duty_motor2 = duty_arr[1];
   assign rsp_duty_motor3 = duty_arr[2];
   assign rsp_duty_motor4 = duty_arr[3];

endmodule

`default_nettype wire

>>> src/mtbc_checker.sv
// ----------------------------------------------------------------------------
// mtbc_checker
// Port-level checks for the motor thrust battery compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [mtbc_pkg::DUTY_W-1:0]        rsp_duty_motor1,
   input wire logic [mtbc_pkg::DUTY_W-1:0]        rsp_duty_motor2,
   input wire logic [mtbc_pkg::DUTY_W-1:0]        rsp_duty_motor3,
   input wire logic [mtbc_pkg::DUTY_W-1:0]        rsp_duty_motor4
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty pipeline takes a request no matter the response side
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!rsp_valid) && $past(!req_valid)) |-> !req_stall)
      else $error("request stalled while pipeline drains empty");

   // duties never exceed the pwm top
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_motor1 <= mtbc_pkg::DUTY_SAT)
                 && (rsp_duty_motor2 <= mtbc_pkg::DUTY_SAT)
                 && (rsp_duty_motor3 <= mtbc_pkg::DUTY_SAT)
                 && (rsp_duty_motor4 <= mtbc_pkg::DUTY_SAT))
      else $error("duty above pwm top");

   // a stalled response holds: valid stays up and the motor1 and motor4 duties are stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_duty_motor1)
                                 && $stable(rsp_duty_motor4))
      else $error("stalled response changed");

endmodule

bind motor_thrust_battery_compensation mtbc_checker u_mtbc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_duty_motor1 (rsp_duty_motor1),
   .rsp_duty_motor2 (rsp_duty_motor2),
   .rsp_duty_motor3 (rsp_duty_motor3),
   .rsp_duty_motor4 (rsp_duty_motor4)
);

`default_nettype wire
